### design/fmiq_pkg.sv
// Shared types, constants and the quarter-wave sine function of the FM I/Q modulator.
package fmiq_pkg;

	// Widths and reset value of the fixed fields.
	localparam int DEV_W    = 31;
	localparam int SAMPLE_W = 8;
	localparam int IQ_W     = 8;
	localparam logic [DEV_W-1:0] DEV_RESET = 31'd76087005;

	// Reciprocal bits the divider multiplies in per cycle.
	localparam int RECIP_CHUNK_BITS = 16;

	// Quarter turn in Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_INC,
		ST_OUT
	} fmiq_state_t;

	// Magnitude of 127*sin(j*pi/(2Q)) with Q = 2**qbits, truncated, from a
	// 15th-order Taylor series in Q30. Evaluated at elaboration only.
	function automatic logic [6:0] quarter_sine(input longint unsigned j, input int qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned v;
		longint s;
		if (j == 64'd0) begin
			return 7'd0;
		end
		if (j >= (64'd1 << qbits)) begin
			return 7'd127;
		end
		x  = (j * HALF_PI_Q30) >> qbits;
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd156;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd210;
		s  = s - longint'(t);
		if (s < 0) begin
			s = 0;
		end
		v = (unsigned'(s) * 64'd127) >> 30;
		if (v > 64'd127) begin
			v = 64'd127;
		end
		return v[6:0];
	endfunction

endpackage

### design/fmiq_divider.sv
// Division of an unsigned value by a fixed divisor as a reciprocal product, one chunk at a time.
module fmiq_divider #(
	parameter int NUM_W   = 36,
	parameter int DIVISOR = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [NUM_W-1:0] dividend,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int CH   = fmiq_pkg::RECIP_CHUNK_BITS;
	localparam int LB   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
	localparam int KS   = NUM_W + LB;
	localparam int RW   = NUM_W + 1;
	localparam int NCH  = (RW + CH - 1) / CH;
	localparam int RPAD = NCH * CH;
	localparam int AW   = NUM_W + CH;
	localparam int FS   = KS - CH * (NCH - 1);
	localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
	// Reciprocal rounded up; with KS = NUM_W + clog2(DIVISOR) the product gives the
	// exact floor of the quotient for every dividend.
	localparam longint unsigned RECIP_L = ((64'd1 << KS) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RPAD-1:0] RECIP   = RPAD'(RECIP_L);

	logic [NUM_W-1:0] num_q;
	logic [RPAD-1:0]  rec_q;
	logic [AW-1:0]    acc_q;
	logic [AW-1:0]    part;
	logic [AW-1:0]    acc_sh;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	// One chunk of the reciprocal per cycle, lowest first; the running sum drops the
	// bits below the next chunk, which leaves the floor unchanged.
	always_comb begin
		part   = (acc_q >> CH) + AW'(num_q) * AW'(rec_q[CH-1:0]);
		acc_sh = acc_q >> FS;
	end

	// Chunk counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(NCH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Dividend held, reciprocal shifted down a chunk at a time, product accumulated.
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= dividend;
			rec_q <= RECIP;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= part;
			rec_q <= rec_q >> CH;
		end
	end

	assign quotient = acc_sh[NUM_W-1:0];
	assign done     = done_q;

endmodule

### design/fmiq_sine_rom.sv
// Quarter-wave sine table with registered sine and cosine reads.
module fmiq_sine_rom #(
	parameter int ADDR_W = 10
) (
	input  logic                               clk,
	input  logic                               rd_en,
	input  logic [ADDR_W-1:0]                  addr,
	output logic signed [fmiq_pkg::IQ_W-1:0]   sine,
	output logic signed [fmiq_pkg::IQ_W-1:0]   cosine
);

	localparam int QB = ADDR_W - 2;
	localparam int Q  = 1 << QB;
	localparam int IW = ADDR_W - 1;

	logic [6:0]    qtab [0:Q];
	logic [1:0]    quad_s;
	logic [1:0]    quad_c;
	logic [QB-1:0] off;
	logic [IW-1:0] idx_s;
	logic [IW-1:0] idx_c;
	logic [6:0]    sin_mag_q;
	logic [6:0]    cos_mag_q;
	logic          sin_neg_q;
	logic          cos_neg_q;

	// Constant table of the first quarter, end points included.
	for (genvar j = 0; j <= Q; j++) begin : g_tab
		localparam logic [6:0] V = fmiq_pkg::quarter_sine(64'(j), QB);
		assign qtab[j] = V;
	end

	// Fold the address into the first quarter; cosine sits one quarter ahead.
	always_comb begin
		quad_s = addr[ADDR_W-1 -: 2];
		quad_c = quad_s + 2'd1;
		off    = addr[QB-1:0];
		idx_s  = quad_s[0] ? (IW'(Q) - IW'(off)) : IW'(off);
		idx_c  = quad_c[0] ? (IW'(Q) - IW'(off)) : IW'(off);
	end

	// Registered table reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			sin_mag_q <= qtab[idx_s];
			cos_mag_q <= qtab[idx_c];
			sin_neg_q <= quad_s[1];
			cos_neg_q <= quad_c[1];
		end
	end

	// The lower half turn gives negative values.
	assign sine   = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
	assign cosine = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});

endmodule

### design/fm_iq_interpolating_modulator.sv
// Top level of the FM I/Q modulator: sequencer, phase accumulator and output register.
//
// An audio sample arrives as one beat on the in_ channel (valid/ready). The block
// centres it, steps linearly from the previous sample to it in SUBSTEPS substeps
// and gives REPEAT I/Q beats per substep on the out_ channel, SUBSTEPS*REPEAT in
// all, the last one with last_of_sample set. in_ready is high only between
// samples. The deviation gain is written through the cfg_ channel, which is
// always ready; it is meant to be written between samples.
// Each substep runs through the states MUL, LOAD, DIV, INC and OUT: the phase
// step of every substep goes through one multiply by the gain and then a
// division by SUBSTEPS formed as a reciprocal product, sixteen reciprocal bits
// a cycle.
// If the receiver stalls, the output register holds its beat and the sequencer
// waits; nothing is lost. Reset restores the default gain and clears the phase
// and the stored previous sample; no clearing pass is needed.
module fm_iq_interpolating_modulator #(
	parameter int SUBSTEPS        = 16,
	parameter int REPEAT          = 4,
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fmiq_pkg::DEV_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [fmiq_pkg::SAMPLE_W-1:0]         audio_sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [fmiq_pkg::IQ_W-1:0]      in_phase,
	output logic signed [fmiq_pkg::IQ_W-1:0]      quadrature,
	output logic                                  last_of_sample
);

	localparam int DEV_W = fmiq_pkg::DEV_W;
	localparam int MAGW  = $clog2(255 * SUBSTEPS + 1);
	localparam int WW    = MAGW + 1;
	localparam int UP    = (PHASE_BITS >= 32) ? (PHASE_BITS - 32) : 0;
	localparam int DOWN  = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
	localparam int PRODW = MAGW + DEV_W;
	localparam int SUMW  = PRODW + UP + 1;
	localparam int SHIFT = 8 + DOWN;
	localparam int NW    = SUMW - SHIFT;
	localparam int MW    = $clog2(SUBSTEPS);
	localparam int RPW   = (REPEAT > 1) ? $clog2(REPEAT) : 1;
	localparam logic [SUMW-1:0]      HALF = SUMW'(128 * SUBSTEPS) << DOWN;
	localparam logic signed [WW-1:0] SM1  = WW'(SUBSTEPS - 1);

	fmiq_pkg::fmiq_state_t state_q, state_d;

	logic [DEV_W-1:0]       dev_q;
	logic signed [8:0]      prev_q;
	logic signed [8:0]      cur;
	logic signed [WW-1:0]   prev_x;
	logic signed [WW-1:0]   cur_x;
	logic signed [WW-1:0]   w0;
	logic signed [WW-1:0]   w_q;
	logic signed [WW-1:0]   delta_q;
	logic signed [WW-1:0]   w_abs;
	logic [MAGW-1:0]        mag;
	logic [PRODW-1:0]       prod_q;
	logic                   neg_q;
	logic [SUMW-1:0]        num;
	logic [NW-1:0]          dividend;
	logic [NW-1:0]          quotient;
	logic                   div_done;
	logic                   div_load;
	logic [PHASE_BITS-1:0]  q_trunc;
	logic [PHASE_BITS-1:0]  inc_q;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [PHASE_BITS-1:0]  phase_next;
	logic [MW-1:0]          m_q;
	logic [RPW-1:0]         rep_q;
	logic                   m_last;
	logic                   rep_last;
	logic                   adv;
	logic                   out_valid_q;
	logic                   last_q;

	// Centre the sample as 2u - 255 and form the first weighted sum.
	always_comb begin
		cur    = {~audio_sample[7], audio_sample[6:0], 1'b1};
		prev_x = {{(WW-9){prev_q[8]}}, prev_q};
		cur_x  = {{(WW-9){cur[8]}}, cur};
		w0     = prev_x * SM1 + cur_x;
	end

	// Magnitude of the weighted sum, rounding offset and the exact power-of-two part
	// of the divisor.
	always_comb begin
		w_abs    = w_q[WW-1] ? -w_q : w_q;
		mag      = w_abs[MAGW-1:0];
		num      = (SUMW'(prod_q) << UP) + HALF;
		dividend = num[SUMW-1:SHIFT];
		q_trunc  = quotient[PHASE_BITS-1:0];
	end

	assign m_last     = (m_q == MW'(SUBSTEPS - 1));
	assign rep_last   = (rep_q == RPW'(REPEAT - 1));
	assign phase_next = phase_q + inc_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fmiq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = fmiq_pkg::ST_MUL;
				end
			end
			fmiq_pkg::ST_MUL:  state_d = fmiq_pkg::ST_LOAD;
			fmiq_pkg::ST_LOAD: state_d = fmiq_pkg::ST_DIV;
			fmiq_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = fmiq_pkg::ST_INC;
				end
			end
			fmiq_pkg::ST_INC:  state_d = fmiq_pkg::ST_OUT;
			fmiq_pkg::ST_OUT: begin
				if (adv && rep_last) begin
					state_d = m_last ? fmiq_pkg::ST_IDLE : fmiq_pkg::ST_MUL;
				end
			end
			default: state_d = fmiq_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		div_load = 1'b0;
		adv      = 1'b0;
		unique case (state_q)
			fmiq_pkg::ST_IDLE: in_ready = 1'b1;
			fmiq_pkg::ST_LOAD: div_load = 1'b1;
			fmiq_pkg::ST_OUT:  adv = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control state, gain register, phase and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fmiq_pkg::ST_IDLE;
			dev_q       <= fmiq_pkg::DEV_RESET;
			prev_q      <= '0;
			phase_q     <= '0;
			m_q         <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				dev_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				prev_q <= cur;
				m_q    <= '0;
				rep_q  <= '0;
			end
			if (adv) begin
				phase_q <= phase_next;
				rep_q   <= rep_last ? '0 : rep_q + 1'b1;
				if (rep_last) begin
					m_q <= m_last ? '0 : m_q + 1'b1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Interpolation sum, product and phase step.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			w_q     <= w0;
			delta_q <= cur_x - prev_x;
		end else if (adv && rep_last) begin
			w_q <= w_q + delta_q;
		end
		if (state_q == fmiq_pkg::ST_MUL) begin
			prod_q <= PRODW'(mag) * PRODW'(dev_q);
			neg_q  <= w_q[WW-1];
		end
		if (state_q == fmiq_pkg::ST_INC) begin
			inc_q <= neg_q ? -q_trunc : q_trunc;
		end
		if (adv) begin
			last_q <= m_last && rep_last;
		end
	end

	fmiq_divider #(
		.NUM_W   (NW),
		.DIVISOR (SUBSTEPS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (dividend),
		.quotient (quotient),
		.done     (div_done)
	);

	fmiq_sine_rom #(
		.ADDR_W (TABLE_ADDR_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (adv),
		.addr   (phase_next[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
		.sine   (in_phase),
		.cosine (quadrature)
	);

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign last_of_sample = last_q;

`ifndef SYNTHESIS
	// The phase step is only formed from a finished quotient.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fmiq_pkg::ST_INC) |-> div_done)
		else $error("phase step taken before the divider finished");

	// A new sample starts only when every substep of the last one is out.
	a_fresh_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (m_q == '0 && rep_q == '0))
		else $error("sample accepted with substeps outstanding");

	// The phase moves only together with an output beat.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q))
		else $error("phase changed without an output beat");
`endif

endmodule

### bench/fm_iq_interpolating_modulator_test.sv
// Self-checking testbench of the FM I/Q modulator: directed table, random audio, I/Q prediction.
module fm_iq_interpolating_modulator_test;

	// Interpolation shape of the block under test (its defaults).
	localparam int SUBSTEPS       = 16;
	localparam int REPEAT         = 4;
	localparam int QUARTER        = 256;
	localparam int SAMPLE_CYCLES  = 177;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int CHUNK_SAMPLES  = 20;
	localparam int HOLD_AFTER     = 64 * 215 + 21;
	localparam int HOLD_CYCLES    = 1500;
	localparam logic [30:0] GAIN_MAX = 31'h7FFFFFFF;

	typedef struct packed {
		logic signed [7:0] sine;
		logic signed [7:0] cosine;
		logic              last;
	} iq_beat_t;

	typedef struct packed {
		logic        set_gain;
		logic [30:0] gain;
		logic [7:0]  sample;
	} stim_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [30:0]            cfg_data     = '0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [7:0]             audio_sample = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic signed [7:0]      in_phase;
	logic signed [7:0]      quadrature;
	logic                   last_of_sample;

	// Mirror of the block's state and its one register.
	logic [30:0] dev_gain     = fmiq_pkg::DEV_RESET;
	int          prev_centred = 0;
	logic [31:0] phase_acc    = '0;

	iq_beat_t    expected_iq[$];
	int          mismatches    = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          beats_seen    = 0;
	int          hold_left     = 0;
	int          cycle_count   = 0;
	logic [7:0]  last_sent     = 8'h80;

	// Extremes of sample and gain, zero and smallest gain, full swings and the zero crossing.
	stim_row_t directed_rows [20] = '{
		'{1'b0, 31'd0, 8'h00},
		'{1'b0, 31'd0, 8'hFF},
		'{1'b0, 31'd0, 8'h7F},
		'{1'b0, 31'd0, 8'h80},
		'{1'b1, GAIN_MAX, 8'hFF},
		'{1'b0, 31'd0, 8'hFF},
		'{1'b0, 31'd0, 8'h00},
		'{1'b0, 31'd0, 8'hFF},
		'{1'b0, 31'd0, 8'h00},
		'{1'b0, 31'd0, 8'h00},
		'{1'b1, 31'd0, 8'hFF},
		'{1'b0, 31'd0, 8'h00},
		'{1'b1, 31'd1, 8'hFF},
		'{1'b0, 31'd0, 8'hFF},
		'{1'b1, 31'h40000000, 8'h55},
		'{1'b0, 31'd0, 8'hAA},
		'{1'b1, 31'h2AAAAAAA, 8'h01},
		'{1'b0, 31'd0, 8'hFE},
		'{1'b1, fmiq_pkg::DEV_RESET, 8'h80},
		'{1'b0, 31'd0, 8'h7F}
	};

	fm_iq_interpolating_modulator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.audio_sample   (audio_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.in_phase       (in_phase),
		.quadrature     (quadrature),
		.last_of_sample (last_of_sample)
	);

	always #6 clk = ~clk;

	// Truncated 127*sin over one quarter turn, from a Taylor series in Q30.
	function automatic int quarter_wave(input int unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint unsigned mag;
		if (j == 0) begin
			return 0;
		end
		if (j >= QUARTER) begin
			return 127;
		end
		x    = (longint'(j) * fmiq_pkg::HALF_PI_Q30) / QUARTER;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		mag = (longint'(acc) * 127) >> 30;
		if (mag > 127) begin
			mag = 127;
		end
		return int'(mag);
	endfunction

	// Full-wave sine at a 10-bit table address, built from quadrant symmetry.
	function automatic logic signed [7:0] sine_at(input logic [9:0] addr);
		int unsigned off;
		off = addr[7:0];
		case (addr[9:8])
			2'd0: return 8'(quarter_wave(off));
			2'd1: return 8'(quarter_wave(QUARTER - off));
			2'd2: return 8'(-quarter_wave(off));
			default: return 8'(-quarter_wave(QUARTER - off));
		endcase
	endfunction

	// Interpolate from the previous sample to this one and queue the I/Q beats it causes.
	task automatic predict_iq(input logic [7:0] sample);
		int              cur;
		int              w;
		longint unsigned mag;
		longint unsigned q;
		logic [31:0]     step;
		logic [9:0]      addr;
		iq_beat_t        beat;
		cur = 2 * int'(sample) - 255;
		for (int m = 0; m < SUBSTEPS; m++) begin
			w    = prev_centred * (SUBSTEPS - 1 - m) + cur * (m + 1);
			mag  = (w < 0) ? longint'(-w) : longint'(w);
			q    = (mag * longint'(dev_gain) + 2048) / 4096;
			step = (w < 0) ? 32'd0 - q[31:0] : q[31:0];
			for (int r = 0; r < REPEAT; r++) begin
				phase_acc   = phase_acc + step;
				addr        = phase_acc[31:22];
				beat.sine   = sine_at(addr);
				beat.cosine = sine_at(addr + 10'd256);
				beat.last   = (m == SUBSTEPS - 1) && (r == REPEAT - 1);
				expected_iq.push_back(beat);
			end
		end
		prev_centred = cur;
	endtask

	// Offer one sample, with a random gap first, and hold it until accepted.
	task automatic send_sample(input logic [7:0] sample);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid     <= 1'b1;
		audio_sample <= sample;
		do @(posedge clk); while (!in_ready);
		predict_iq(sample);
		last_sent = sample;
	endtask

	// Wait until every expected beat is out, then write the deviation gain.
	task automatic write_gain(input logic [30:0] gain);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_iq.size() != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= gain;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dev_gain = gain;
	endtask

	function automatic logic [30:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return GAIN_MAX;
			1: return 31'd0;
			2: return fmiq_pkg::DEV_RESET;
			3: return 31'($urandom_range(0, 1 << 24));
			default: return 31'($urandom());
		endcase
	endfunction

	// Mostly slowly moving audio, some jumps and rail-to-rail steps.
	function automatic logic [7:0] pick_sample(input logic [7:0] prev);
		int v;
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			1, 2: return 8'($urandom());
			default: begin
				v = int'(prev) + int'($urandom_range(0, 40)) - 20;
				if (v < 0) begin
					v = 0;
				end else if (v > 255) begin
					v = 255;
				end
				return 8'(v);
			end
		endcase
	endfunction

	// Receiver: stalls at random, once holds off for a long stretch, and checks each beat.
	always @(posedge clk) begin
		iq_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_iq.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat: in_phase %0d quadrature %0d last %0b",
					$time, in_phase, quadrature, last_of_sample);
			end else begin
				want = expected_iq.pop_front();
				if (in_phase !== want.sine) begin
					mismatches++;
					$display("%0t: in_phase expected %0d, got %0d", $time, want.sine, in_phase);
				end
				if (quadrature !== want.cosine) begin
					mismatches++;
					$display("%0t: quadrature expected %0d, got %0d",
						$time, want.cosine, quadrature);
				end
				if (last_of_sample !== want.last) begin
					mismatches++;
					$display("%0t: last_of_sample expected %0b, got %0b",
						$time, want.last, last_of_sample);
				end
			end
			beats_seen++;
			if (beats_seen == HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fm_iq_interpolating_modulator_test NOT OK");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random audio over three idling patterns.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[row]) begin
			if (directed_rows[row].set_gain) begin
				write_gain(directed_rows[row].gain);
			end
			send_sample(directed_rows[row].sample);
		end

		for (int pattern = 0; pattern < 3; pattern++) begin
			case (pattern)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int chunk = 0; chunk < 4; chunk++) begin
				write_gain(pick_gain());
				for (int k = 0; k < CHUNK_SAMPLES; k++) begin
					send_sample(pick_sample(last_sent));
				end
			end
		end

		// Drain, then give the block time to show any stray beats.
		in_valid <= 1'b0;
		while (expected_iq.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * SAMPLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("fm_iq_interpolating_modulator_test OK");
		end else begin
			$display("fm_iq_interpolating_modulator_test NOT OK");
		end
		$finish;
	end

endmodule

### sim.f
design/fmiq_pkg.sv
design/fmiq_divider.sv
design/fmiq_sine_rom.sv
design/fm_iq_interpolating_modulator.sv
bench/fm_iq_interpolating_modulator_test.sv
